// File: rtl/core/acc_cpu_pkg.sv
// Shared types, constants and functions of the accumulator CPU step block.
package acc_cpu_pkg;

  localparam int ADDR_W      = 11;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [4:0] CODE_WM   = 5'h01;
  localparam logic [4:0] CODE_RM   = 5'h02;
  localparam logic [4:0] CODE_WB   = 5'h06;
  localparam logic [4:0] CODE_WACC = 5'h09;
  localparam logic [4:0] CODE_RACC = 5'h0B;
  localparam logic [4:0] CODE_SHR  = 5'h15;
  localparam logic [4:0] CODE_SHL  = 5'h16;
  localparam logic [4:0] CODE_XOR  = 5'h17;
  localparam logic [4:0] CODE_NOT  = 5'h18;
  localparam logic [4:0] CODE_OR   = 5'h19;
  localparam logic [4:0] CODE_AND  = 5'h1A;
  localparam logic [4:0] CODE_MUL  = 5'h1B;
  localparam logic [4:0] CODE_BAD  = 5'h1C;
  localparam logic [4:0] CODE_SUB  = 5'h1D;
  localparam logic [4:0] CODE_ADD  = 5'h1E;
  localparam logic [4:0] CODE_EOP  = 5'h1F;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam int FL_ZERO  = 0;
  localparam int FL_CARRY = 1;
  localparam int FL_SIGN  = 6;
  localparam int FL_OVER  = 7;

  typedef enum logic [4:0] {
    K_NOP, K_WM, K_RM, K_WB, K_WACC, K_RACC,
    K_SHR, K_SHL, K_XOR, K_NOT, K_OR, K_AND, K_MUL, K_SUB, K_ADD,
    K_BAD, K_EOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               load_mbr;
    logic [7:0]         mbr_value;
    logic [ADDR_W-1:0]  address;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } req_t;

  typedef enum logic {
    EX_RUN,
    EX_RD_WAIT
  } ex_state_t;

  function automatic logic [15:0] booth8(input logic [7:0] m, input logic [7:0] q_in);
    logic [7:0] a;
    logic [7:0] q;
    logic       qm1;
    a   = 8'h00;
    q   = q_in;
    qm1 = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (q[0] && !qm1) begin
        a = a - m;
      end else if (!q[0] && qm1) begin
        a = a + m;
      end
      qm1 = q[0];
      q   = {a[0], q[7:1]};
      a   = {a[7], a[7:1]};
    end
    return {a, q};
  endfunction

  function automatic logic [7:0] alu_flags(input logic [31:0] v);
    logic [7:0] f;
    f           = 8'h00;
    f[FL_ZERO]  = (v == 32'd0);
    f[FL_SIGN]  = v[7];
    f[FL_CARRY] = !v[31] && (|v[30:8]);
    f[FL_OVER]  = !v[31] && (|v[30:7]);
    return f;
  endfunction

endpackage

// File: rtl/core/acc_cpu_ram.sv
// Generic single-write, registered-read RAM.
module acc_cpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/acc_cpu_front.sv
// Front end: accept requests, decode the instruction code and queue them.
module acc_cpu_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [4:0]                 in_mode,
  input  logic                       in_load_mbr,
  input  logic [7:0]                 in_mbr_value,
  input  logic [acc_cpu_pkg::ADDR_W-1:0] in_address,
  output acc_cpu_pkg::req_t          head,
  input  logic                       head_pop
);

  localparam int PW = $clog2(acc_cpu_pkg::FIFO_DEPTH);

  acc_cpu_pkg::item_t ent_r [acc_cpu_pkg::FIFO_DEPTH];
  logic [PW-1:0]      wr_ptr_r;
  logic [PW-1:0]      rd_ptr_r;
  logic [PW:0]        cnt_r;
  acc_cpu_pkg::item_t dec;
  logic               do_push;
  logic               do_pop;

  function automatic acc_cpu_pkg::kind_t decode(input logic [4:0] code);
    acc_cpu_pkg::kind_t k;
    unique case (code)
      acc_cpu_pkg::CODE_WM:   k = acc_cpu_pkg::K_WM;
      acc_cpu_pkg::CODE_RM:   k = acc_cpu_pkg::K_RM;
      acc_cpu_pkg::CODE_WB:   k = acc_cpu_pkg::K_WB;
      acc_cpu_pkg::CODE_WACC: k = acc_cpu_pkg::K_WACC;
      acc_cpu_pkg::CODE_RACC: k = acc_cpu_pkg::K_RACC;
      acc_cpu_pkg::CODE_SHR:  k = acc_cpu_pkg::K_SHR;
      acc_cpu_pkg::CODE_SHL:  k = acc_cpu_pkg::K_SHL;
      acc_cpu_pkg::CODE_XOR:  k = acc_cpu_pkg::K_XOR;
      acc_cpu_pkg::CODE_NOT:  k = acc_cpu_pkg::K_NOT;
      acc_cpu_pkg::CODE_OR:   k = acc_cpu_pkg::K_OR;
      acc_cpu_pkg::CODE_AND:  k = acc_cpu_pkg::K_AND;
      acc_cpu_pkg::CODE_MUL:  k = acc_cpu_pkg::K_MUL;
      acc_cpu_pkg::CODE_BAD:  k = acc_cpu_pkg::K_BAD;
      acc_cpu_pkg::CODE_SUB:  k = acc_cpu_pkg::K_SUB;
      acc_cpu_pkg::CODE_ADD:  k = acc_cpu_pkg::K_ADD;
      acc_cpu_pkg::CODE_EOP:  k = acc_cpu_pkg::K_EOP;
      default:                k = acc_cpu_pkg::K_NOP;
    endcase
    return k;
  endfunction

  always_comb begin
    dec.kind      = decode(in_mode);
    dec.load_mbr  = in_load_mbr;
    dec.mbr_value = in_mbr_value;
    dec.address   = in_address;
  end

  assign full       = (cnt_r == (PW+1)'(acc_cpu_pkg::FIFO_DEPTH));
  assign do_push    = push && !full;
  assign do_pop     = head_pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.item  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/acc_cpu_back.sv
// Back end: execute queued instructions on the machine state and hold the result.
module acc_cpu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acc_cpu_pkg::req_t    head,
  output logic                 head_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [31:0]   out_acc,
  output logic [7:0]           out_flags,
  output logic [7:0]           out_buffer_out,
  output logic [7:0]           out_bus_out,
  output logic [1:0]           out_status
);

  acc_cpu_pkg::ex_state_t state_r, state_nxt;

  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  buf_r, buf_nxt;
  logic [7:0]  bus_r, bus_nxt;
  logic [7:0]  flg_r, flg_nxt;
  logic        halted_r, halted_nxt;
  logic [1:0]  status_nxt;

  logic        out_valid_r;
  logic [31:0] out_acc_r;
  logic [7:0]  out_flg_r;
  logic [7:0]  out_buf_r;
  logic [7:0]  out_bus_r;
  logic [1:0]  out_st_r;

  logic        out_free;
  logic        fire;
  logic        out_ld;
  logic        ram_we;
  logic        ram_re;
  logic [7:0]  ram_rdata;
  logic [7:0]  buf_ld;
  logic [31:0] bus_ext;

  acc_cpu_ram #(
    .WIDTH (8),
    .DEPTH (acc_cpu_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.item.address),
    .wdata (buf_ld),
    .re    (ram_re),
    .raddr (head.item.address),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || pop;
  assign fire     = (state_r == acc_cpu_pkg::EX_RUN) && head.valid && out_free;
  assign buf_ld   = head.item.load_mbr ? head.item.mbr_value : buf_r;
  assign bus_ext  = {24'd0, bus_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      acc_cpu_pkg::EX_RUN: begin
        if (fire && !halted_r && head.item.kind == acc_cpu_pkg::K_RM) begin
          state_nxt = acc_cpu_pkg::EX_RD_WAIT;
        end
      end
      acc_cpu_pkg::EX_RD_WAIT: begin
        state_nxt = acc_cpu_pkg::EX_RUN;
      end
      default: state_nxt = acc_cpu_pkg::EX_RUN;
    endcase
  end

  always_comb begin
    acc_nxt    = acc_r;
    buf_nxt    = buf_r;
    bus_nxt    = bus_r;
    flg_nxt    = flg_r;
    halted_nxt = halted_r;
    status_nxt = acc_cpu_pkg::ST_OK;
    head_pop   = 1'b0;
    out_ld     = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    unique case (state_r)
      acc_cpu_pkg::EX_RUN: begin
        if (fire) begin
          head_pop = 1'b1;
          if (halted_r) begin
            status_nxt = acc_cpu_pkg::ST_HALT;
            out_ld     = 1'b1;
          end else begin
            buf_nxt = buf_ld;
            out_ld  = 1'b1;
            unique case (head.item.kind)
              acc_cpu_pkg::K_WM: begin
                bus_nxt = buf_ld;
                ram_we  = 1'b1;
              end
              acc_cpu_pkg::K_RM: begin
                ram_re = 1'b1;
                out_ld = 1'b0;
              end
              acc_cpu_pkg::K_WB:   bus_nxt = buf_ld;
              acc_cpu_pkg::K_WACC: acc_nxt = {24'd0, buf_ld};
              acc_cpu_pkg::K_RACC: buf_nxt = acc_r[7:0];
              acc_cpu_pkg::K_SHR:  acc_nxt = {25'd0, acc_r[7:1]};
              acc_cpu_pkg::K_SHL:  acc_nxt = {acc_r[30:0], 1'b0};
              acc_cpu_pkg::K_XOR:  acc_nxt = acc_r ^ bus_ext;
              acc_cpu_pkg::K_NOT:  acc_nxt = ~acc_r;
              acc_cpu_pkg::K_OR:   acc_nxt = acc_r | bus_ext;
              acc_cpu_pkg::K_AND:  acc_nxt = acc_r & bus_ext;
              acc_cpu_pkg::K_MUL:  acc_nxt = {16'd0, acc_cpu_pkg::booth8(acc_r[7:0], bus_r)};
              acc_cpu_pkg::K_SUB:  acc_nxt = acc_r - bus_ext;
              acc_cpu_pkg::K_ADD:  acc_nxt = acc_r + bus_ext;
              acc_cpu_pkg::K_BAD:  status_nxt = acc_cpu_pkg::ST_BAD;
              acc_cpu_pkg::K_EOP: begin
                halted_nxt = 1'b1;
                status_nxt = acc_cpu_pkg::ST_HALT;
              end
              default: ;
            endcase
            priority if (head.item.kind == acc_cpu_pkg::K_SHR ||
                         head.item.kind == acc_cpu_pkg::K_SHL ||
                         head.item.kind == acc_cpu_pkg::K_XOR ||
                         head.item.kind == acc_cpu_pkg::K_NOT ||
                         head.item.kind == acc_cpu_pkg::K_OR  ||
                         head.item.kind == acc_cpu_pkg::K_AND ||
                         head.item.kind == acc_cpu_pkg::K_MUL ||
                         head.item.kind == acc_cpu_pkg::K_SUB ||
                         head.item.kind == acc_cpu_pkg::K_ADD) begin
              flg_nxt = acc_cpu_pkg::alu_flags(acc_nxt);
            end else begin
              flg_nxt = flg_r;
            end
          end
        end
      end
      acc_cpu_pkg::EX_RD_WAIT: begin
        bus_nxt = ram_rdata;
        buf_nxt = ram_rdata;
        out_ld  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= acc_cpu_pkg::EX_RUN;
      acc_r    <= '0;
      buf_r    <= '0;
      bus_r    <= '0;
      flg_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_r    <= acc_nxt;
      buf_r    <= buf_nxt;
      bus_r    <= bus_nxt;
      flg_r    <= flg_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_acc_r <= acc_nxt;
      out_flg_r <= flg_nxt;
      out_buf_r <= buf_nxt;
      out_bus_r <= bus_nxt;
      out_st_r  <= status_nxt;
    end
  end

  assign empty          = !out_valid_r;
  assign out_acc        = signed'(out_acc_r);
  assign out_flags      = out_flg_r;
  assign out_buffer_out = out_buf_r;
  assign out_bus_out    = out_bus_r;
  assign out_status     = out_st_r;

endmodule

// File: rtl/core/accumulator_cpu_step.sv
// Top level of the accumulator CPU step block.
//
// Requests enter through a queue-style port: an instruction is taken when
// push is high and full is low. One result leaves per request through the
// empty/pop port; the oldest result is shown while empty is low and is taken
// when pop is high. A decoding front end feeds a two-entry queue; the back
// end executes one instruction per cycle while the result register is free,
// moving its result from the queue entry into the result register. A memory
// read passes through the wait state EX_RD_WAIT for the registered read of
// the 2048-byte store, and the back end takes no new request in that state.
// When the receiver stalls, the result register holds, the back end stops
// and the queue fills until full rises. Synchronous reset clears the
// accumulator, buffer, bus byte, flags and halt state and empties the
// request queue and the result register; the store keeps its contents and
// is undefined until written. After end of program every later request
// returns the held state with halted status until reset.
module accumulator_cpu_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [4:0]           in_mode,
  input  logic                 in_load_mbr,
  input  logic [7:0]           in_mbr_value,
  input  logic [10:0]          in_address,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [31:0]   out_acc,
  output logic [7:0]           out_flags,
  output logic [7:0]           out_buffer_out,
  output logic [7:0]           out_bus_out,
  output logic [1:0]           out_status
);

  acc_cpu_pkg::req_t head;
  logic              head_pop;

  acc_cpu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_mode      (in_mode),
    .in_load_mbr  (in_load_mbr),
    .in_mbr_value (in_mbr_value),
    .in_address   (in_address[acc_cpu_pkg::ADDR_W-1:0]),
    .head         (head),
    .head_pop     (head_pop)
  );

  acc_cpu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .head_pop       (head_pop),
    .empty          (empty),
    .pop            (pop),
    .out_acc        (out_acc),
    .out_flags      (out_flags),
    .out_buffer_out (out_buffer_out),
    .out_bus_out    (out_bus_out),
    .out_status     (out_status)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_status == acc_cpu_pkg::ST_HALT) |=>
      (empty || out_status == acc_cpu_pkg::ST_HALT))
    else $error("result after halt not marked halted");

  a_carry_over: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_flags[acc_cpu_pkg::FL_CARRY]) |-> out_flags[acc_cpu_pkg::FL_OVER])
    else $error("carry flag without overflow flag");

  a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> head.valid)
    else $error("queue pop with no request waiting");

endmodule

// File: bench/acc_cpu_step_checker.sv
// Checker for accumulator_cpu_step: predicts each request's result and compares it on the output.
`timescale 1ns / 100ps
module acc_cpu_step_checker
  import acc_cpu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              full,
  input  logic [4:0]        in_mode,
  input  logic              in_load_mbr,
  input  logic [7:0]        in_mbr_value,
  input  logic [ADDR_W-1:0] in_address,
  input  logic              empty,
  input  logic              pop,
  input  logic [31:0]       out_acc,
  input  logic [7:0]        out_flags,
  input  logic [7:0]        out_buffer_out,
  input  logic [7:0]        out_bus_out,
  input  logic [1:0]        out_status,
  output int                mismatches,
  output int                pending
);

  typedef struct packed {
    logic [31:0] acc;
    logic [7:0]  flags;
    logic [7:0]  buffer;
    logic [7:0]  bus;
    logic [1:0]  status;
  } step_result_t;

  logic [31:0]  acc_q;
  logic [7:0]   buf_q;
  logic [7:0]   bus_q;
  logic [7:0]   flag_q;
  logic         halt_q;
  logic [7:0]   mem_q [STORE_DEPTH];
  step_result_t expected_steps [$];
  step_result_t want;

  function automatic logic [15:0] booth_product(input logic [7:0] mcand,
                                                input logic [7:0] mplier);
    logic [16:0] p;
    p = {8'h00, mplier, 1'b0};
    for (int i = 0; i < 8; i++) begin
      case (p[1:0])
        2'b01: p[16:9] = p[16:9] + mcand;
        2'b10: p[16:9] = p[16:9] - mcand;
        default: ;
      endcase
      p = {p[16], p[16:1]};
    end
    return p[16:1];
  endfunction

  function automatic logic [7:0] alu_flag_byte(input logic [31:0] v);
    logic [7:0] f;
    f           = 8'h00;
    f[FL_ZERO]  = (v == 32'd0);
    f[FL_SIGN]  = v[7];
    f[FL_CARRY] = ($signed(v) > 255);
    f[FL_OVER]  = ($signed(v) > 127);
    return f;
  endfunction

  function automatic step_result_t execute_instruction(input logic [4:0] code,
                                                       input logic ld,
                                                       input logic [7:0] val,
                                                       input logic [ADDR_W-1:0] addr);
    step_result_t r;
    logic [31:0]  alu;
    logic         is_alu;
    r.status = ST_OK;
    if (halt_q) begin
      r.status = ST_HALT;
    end else begin
      if (ld) begin
        buf_q = val;
      end
      alu    = acc_q;
      is_alu = (code >= CODE_SHR) && (code <= CODE_ADD) && (code != CODE_BAD);
      case (code)
        CODE_WACC: acc_q = {24'h0, buf_q};
        CODE_RACC: buf_q = acc_q[7:0];
        CODE_WB:   bus_q = buf_q;
        CODE_RM: begin
          bus_q = mem_q[addr];
          buf_q = bus_q;
        end
        CODE_WM: begin
          bus_q       = buf_q;
          mem_q[addr] = bus_q;
        end
        CODE_ADD:  alu = acc_q + {24'h0, bus_q};
        CODE_SUB:  alu = acc_q - {24'h0, bus_q};
        CODE_MUL:  alu = {16'h0, booth_product(acc_q[7:0], bus_q)};
        CODE_AND:  alu = acc_q & {24'h0, bus_q};
        CODE_OR:   alu = acc_q | {24'h0, bus_q};
        CODE_XOR:  alu = acc_q ^ {24'h0, bus_q};
        CODE_NOT:  alu = ~acc_q;
        CODE_SHL:  alu = acc_q << 1;
        CODE_SHR:  alu = {25'h0, acc_q[7:1]};
        CODE_BAD:  r.status = ST_BAD;
        CODE_EOP: begin
          halt_q   = 1'b1;
          r.status = ST_HALT;
        end
        default: ;
      endcase
      if (is_alu) begin
        acc_q  = alu;
        flag_q = alu_flag_byte(alu);
      end
    end
    r.acc    = acc_q;
    r.flags  = flag_q;
    r.buffer = buf_q;
    r.bus    = bus_q;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_val,
                 got_val);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      acc_q  = '0;
      buf_q  = '0;
      bus_q  = '0;
      flag_q = '0;
      halt_q = 1'b0;
      expected_steps.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_steps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with no request waiting, acc %0h status %0h", $realtime,
                     out_acc, out_status);
          end
        end else begin
          want = expected_steps.pop_front();
          compare_field("acc", want.acc, out_acc);
          compare_field("flags", 32'(want.flags), 32'(out_flags));
          compare_field("buffer_out", 32'(want.buffer), 32'(out_buffer_out));
          compare_field("bus_out", 32'(want.bus), 32'(out_bus_out));
          compare_field("status", 32'(want.status), 32'(out_status));
        end
      end
      if (push && !full) begin
        expected_steps.push_back(execute_instruction(in_mode, in_load_mbr, in_mbr_value,
                                                     in_address));
      end
    end
    pending = expected_steps.size();
  end

endmodule

// File: bench/tb_accumulator_cpu_step.sv
// Testbench top for accumulator_cpu_step: drives directed and random requests and gives the verdict.
`timescale 1ns / 100ps
module tb_accumulator_cpu_step;
  import acc_cpu_pkg::*;

  localparam int RANDOM_REQUESTS = 1350;
  localparam int PHASES          = 4;
  localparam int TAIL_REQUESTS   = 15;

  localparam logic [4:0] CODE_ZERO   = 5'h00;
  localparam logic [4:0] CODE_UNUSED = 5'h03;
  localparam logic [4:0] CODE_BRANCH = 5'h11;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                push         = 1'b0;
  logic                pop          = 1'b0;
  logic [4:0]          in_mode      = '0;
  logic                in_load_mbr  = 1'b0;
  logic [7:0]          in_mbr_value = '0;
  logic [ADDR_W-1:0]   in_address   = '0;
  logic                full;
  logic                empty;
  logic signed [31:0]  out_acc;
  logic [7:0]          out_flags;
  logic [7:0]          out_buffer_out;
  logic [7:0]          out_bus_out;
  logic [1:0]          out_status;

  int mismatches;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int send_idle_by_phase  [PHASES] = '{0, 57, 0, 7};
  int recv_stall_by_phase [PHASES] = '{0, 0, 57, 7};

  bit written [STORE_DEPTH];
  int written_addrs [$];
  bit halt_issued = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  accumulator_cpu_step DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_mode        (in_mode),
    .in_load_mbr    (in_load_mbr),
    .in_mbr_value   (in_mbr_value),
    .in_address     (in_address),
    .empty          (empty),
    .pop            (pop),
    .out_acc        (out_acc),
    .out_flags      (out_flags),
    .out_buffer_out (out_buffer_out),
    .out_bus_out    (out_bus_out),
    .out_status     (out_status)
  );

  acc_cpu_step_checker step_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_mode        (in_mode),
    .in_load_mbr    (in_load_mbr),
    .in_mbr_value   (in_mbr_value),
    .in_address     (in_address),
    .empty          (empty),
    .pop            (pop),
    .out_acc        (out_acc),
    .out_flags      (out_flags),
    .out_buffer_out (out_buffer_out),
    .out_bus_out    (out_bus_out),
    .out_status     (out_status),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  always @(negedge clk) begin
    pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic issue_request(input logic [4:0] m, input logic ld, input logic [7:0] v,
                               input logic [ADDR_W-1:0] a);
    if (m == CODE_WM && !halt_issued && !written[a]) begin
      written[a] = 1'b1;
      written_addrs.push_back(int'(a));
    end
    if (m == CODE_EOP) begin
      halt_issued = 1'b1;
    end
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push         <= 1'b1;
    in_mode      <= m;
    in_load_mbr  <= ld;
    in_mbr_value <= v;
    in_address   <= a;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic issue_random_request(input bit allow_halt);
    int                pick;
    logic [4:0]        m;
    logic              ld;
    logic [7:0]        v;
    logic [ADDR_W-1:0] a;
    pick = $urandom_range(99);
    ld   = 1'($urandom_range(1));
    v    = 8'($urandom);
    if ($urandom_range(7) == 0) begin
      v = {v[7], {7{v[6]}}};
    end
    a = ($urandom_range(3) != 0) ? ADDR_W'($urandom_range(63)) : ADDR_W'($urandom);
    if (pick < 12) begin
      m = CODE_WM;
    end else if (pick < 22) begin
      m = CODE_RM;
    end else if (pick < 30) begin
      m = CODE_WB;
    end else if (pick < 36) begin
      m = CODE_WACC;
    end else if (pick < 40) begin
      m = CODE_RACC;
    end else if (pick < 88) begin
      m = 5'($urandom_range(CODE_SHR, CODE_ADD));
    end else begin
      m = 5'($urandom_range(allow_halt ? CODE_EOP : CODE_EOP - 5'd1));
    end
    if (m == CODE_RM && !written[a]) begin
      if (written_addrs.size() == 0) begin
        m = CODE_WM;
      end else begin
        a = ADDR_W'(written_addrs[$urandom_range(written_addrs.size() - 1)]);
      end
    end
    issue_request(m, ld, v, a);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    issue_request(CODE_WACC, 1'b1, 8'h00, 11'h000);
    issue_request(CODE_WB, 1'b1, 8'hFF, 11'h7FF);
    issue_request(CODE_ADD, 1'b0, 8'h00, 11'h000);
    issue_request(CODE_WB, 1'b1, 8'h01, 11'h000);
    issue_request(CODE_ADD, 1'b0, 8'h00, 11'h000);
    issue_request(CODE_SHR, 1'b0, 8'h00, 11'h000);
    issue_request(CODE_NOT, 1'b0, 8'h00, 11'h000);
    issue_request(CODE_SHL, 1'b0, 8'h00, 11'h000);
    issue_request(CODE_SUB, 1'b0, 8'h00, 11'h000);
    issue_request(CODE_WB, 1'b1, 8'h80, 11'h000);
    issue_request(CODE_WACC, 1'b1, 8'h80, 11'h000);
    issue_request(CODE_MUL, 1'b0, 8'h00, 11'h000);
    issue_request(CODE_WB, 1'b1, 8'h7F, 11'h000);
    issue_request(CODE_WACC, 1'b1, 8'h81, 11'h000);
    issue_request(CODE_MUL, 1'b0, 8'h00, 11'h000);
    issue_request(CODE_XOR, 1'b0, 8'h00, 11'h000);
    issue_request(CODE_OR, 1'b0, 8'h00, 11'h000);
    issue_request(CODE_AND, 1'b0, 8'h00, 11'h000);
    issue_request(CODE_WM, 1'b1, 8'hA5, 11'h000);
    issue_request(CODE_WM, 1'b1, 8'h5A, 11'h7FF);
    issue_request(CODE_RM, 1'b1, 8'h33, 11'h7FF);
    issue_request(CODE_RM, 1'b0, 8'h00, 11'h000);
    issue_request(CODE_RACC, 1'b0, 8'h00, 11'h000);
    issue_request(CODE_BAD, 1'b1, 8'h3C, 11'h000);
    issue_request(CODE_BRANCH, 1'b1, 8'hC3, 11'h000);
    issue_request(CODE_UNUSED, 1'b1, 8'h96, 11'h000);
    issue_request(CODE_ZERO, 1'b0, 8'h00, 11'h000);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      send_idle_pct  = send_idle_by_phase[phase];
      recv_stall_pct = recv_stall_by_phase[phase];
      for (int n = 0; n < RANDOM_REQUESTS / PHASES; n++) begin
        issue_random_request(1'b0);
      end
    end

    issue_request(CODE_EOP, 1'($urandom), 8'($urandom), ADDR_W'($urandom));
    for (int n = 0; n < TAIL_REQUESTS; n++) begin
      issue_random_request(1'b1);
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_accumulator_cpu_step passed");
    end else begin
      $display("tb_accumulator_cpu_step failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_accumulator_cpu_step failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/acc_cpu_pkg.sv
rtl/core/acc_cpu_ram.sv
rtl/core/acc_cpu_front.sv
rtl/core/acc_cpu_back.sv
rtl/core/accumulator_cpu_step.sv
bench/acc_cpu_step_checker.sv
bench/tb_accumulator_cpu_step.sv
